/* hw/rtl/ira_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ira_pkg
// shared types, constants, the digit-to-ascii mapping and the radix clamp for
// the radix converter
// ----------------------------------------------------------------------------
package ira_pkg;

  // radix limits and reset value
  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam logic [5:0] RADIX_RESET = 6'd36;

  // register byte addresses
  localparam logic [2:0] REG_RADIX_ADDR = 3'd0;

  // ascii anchors
  localparam logic [6:0] ASCII_ZERO = 7'h30;
  localparam logic [6:0] ASCII_A    = 7'h41;
  localparam logic [5:0] DEC_LIMIT  = 6'd9;
  localparam logic [6:0] DEC_COUNT  = 7'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_LOAD,
    ST_ZERO
  } state_t;

  function automatic logic [6:0] digit_to_ascii(input logic [5:0] d);
    logic [6:0] res;
    if (d <= DEC_LIMIT) begin
      res = {1'b0, d} + ASCII_ZERO;
    end else begin
      res = {1'b0, d} - DEC_COUNT + ASCII_A;
    end
    return res;
  endfunction

  function automatic logic [5:0] clamp_radix(input logic [5:0] r);
    logic [5:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

endpackage

/* hw/rtl/integer_to_radix_ascii_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_top
// converts a non-negative integer to ascii digits in a radix from 2 to 36
// ----------------------------------------------------------------------------
// One input beat carries an unsigned value; the block answers with one output
// beat per digit in the radix held in the radix register, most significant
// digit first, tlast on the final digit. A zero value gives a single beat with
// tuser set and a null character. Radix values below 2 act as 2, above 36 as
// 36. Digits come from a bit-serial divider that produces one quotient bit per
// cycle on QW = min(VALUE_BITS, 31) bits, the width of the value after masking;
// each digit is then read back from the registered digit store (ST_READ, then
// ST_LOAD, which waits for a free output register). One item is in work at a
// time, but the last digit sits in the output register so a new value is taken
// while it waits. Write the radix only while the block is idle.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_top
  import ira_pkg::*;
#(
  parameter int VALUE_BITS = 31
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [30:0] value, [31] zero fill
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] digit_char, [7] zero fill
  output logic        m_tlast,   // last
  output logic        m_tuser,   // empty_res
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // value width after masking to both the parameter and the field
  localparam int QW    = (VALUE_BITS < 31) ? VALUE_BITS : 31;
  localparam int AW    = $clog2(VALUE_BITS);
  localparam int CNT_W = $clog2(QW + 1);

  state_t state, state_next;

  logic [5:0]       radix;
  logic [5:0]       radix_eff;
  logic [CNT_W-1:0] count, count_next;
  logic [AW-1:0]    rd_idx, rd_idx_next;

  // output register
  logic             out_valid, out_valid_next;
  logic [6:0]       out_char, out_char_next;
  logic             out_last, out_last_next;
  logic             out_empty, out_empty_next;
  logic             out_free;

  // divider hookup
  logic             div_start;
  logic [QW-1:0]    div_dividend;
  logic             div_done;
  logic [QW-1:0]    div_quo;
  logic [5:0]       div_rem;

  // digit store
  logic             ram_we;
  logic [5:0]       ram_rdata;

  logic [QW-1:0]    in_value;
  logic             in_beat;

  assign in_value = s_tdata[QW-1:0];
  assign in_beat  = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign out_free = !out_valid || m_tready;

  // ---------------- register port ----------------
  assign pready    = 1'b1;
  assign prdata    = {26'd0, radix};
  assign radix_eff = clamp_radix(radix);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_RADIX_ADDR) begin
      radix <= pwdata[5:0];
    end
  end

  // ---------------- divider and store ----------------
  ira_divider #(
    .QW (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (radix_eff),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // remainders land at the digit count, least significant digit at entry 0
  ira_ram #(
    .WIDTH (6),
    .DEPTH (VALUE_BITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(count)),
    .wdata (div_rem),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rd_idx    <= rd_idx_next;
      out_valid <= out_valid_next;
    end
  end

  // output payload needs no reset
  always_ff @(posedge clk) begin
    out_char  <= out_char_next;
    out_last  <= out_last_next;
    out_empty <= out_empty_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    rd_idx_next    = rd_idx;
    div_start      = 1'b0;
    div_dividend   = div_quo;
    ram_we         = 1'b0;
    out_valid_next = out_valid && !m_tready;
    out_char_next  = out_char;
    out_last_next  = out_last;
    out_empty_next = out_empty;

    unique case (state)
      ST_IDLE: begin
        div_dividend = in_value;
        if (in_beat) begin
          count_next = '0;
          if (in_value == '0) begin
            state_next = ST_ZERO;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ram_we     = 1'b1;
          count_next = count + 1'b1;
          if (div_quo == '0) begin
            // top digit is the one just stored
            rd_idx_next = AW'(count);
            state_next  = ST_READ;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_char_next  = digit_to_ascii(ram_rdata);
          out_last_next  = (rd_idx == '0);
          out_empty_next = 1'b0;
          if (rd_idx == '0) begin
            state_next = ST_IDLE;
          end else begin
            rd_idx_next = rd_idx - 1'b1;
            state_next  = ST_READ;
          end
        end
      end
      ST_ZERO: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_char_next  = '0;
          out_last_next  = 1'b1;
          out_empty_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_char};
  assign m_tlast  = out_last;
  assign m_tuser  = out_empty;

  // ---------------- checks ----------------
  // an empty result is always a lone zero beat
  a_empty_lone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && m_tdata == 8'd0)
    else $error("empty result without last or with nonzero character");

  // a digit beat carries a legal digit character
  a_digit_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |->
      (m_tdata[6:0] >= ASCII_ZERO && m_tdata[6:0] <= ASCII_ZERO + 7'd9) ||
      (m_tdata[6:0] >= ASCII_A && m_tdata[6:0] <= ASCII_A + 7'd25))
    else $error("digit character out of range");

  // the divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider done outside division phase");

  // never more digits than value bits
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QW))
    else $error("digit count overflow");

endmodule

/* hw/rtl/ira_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ira_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ira_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/ira_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ira_divider
// bit-serial restoring divider: one quotient bit per cycle, 6-bit divisor
// ----------------------------------------------------------------------------
module ira_divider #(
  parameter int QW = 31
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [QW-1:0] dividend,
  input  logic [5:0]    divisor,
  output logic          done,
  output logic [QW-1:0] quo,
  output logic [5:0]    rem
);

  localparam int BW = $clog2(QW);

  logic          busy;
  logic [BW-1:0] bitcnt;
  logic [6:0]    trial;
  logic          ge;
  logic [6:0]    diff;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem, quo[QW-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      bitcnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        bitcnt <= '0;
      end else if (busy) begin
        bitcnt <= bitcnt + 1'b1;
        if (bitcnt == BW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[QW-2:0], ge};
      rem <= ge ? diff[5:0] : trial[5:0];
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the integer to radix ascii converter
// ----------------------------------------------------------------------------
// Values stream in on the slave side and ascii digit beats are checked on the
// master side against a local digit predictor: most significant digit first,
// tlast on the final digit, tuser alone on the single beat for a zero value.
// The run opens with directed values (zero, one, radix boundaries, all-ones,
// alternating bits, the longest digit string) and then goes through phases of
// random values, one radix setting per phase, the out-of-range settings among
// them. Both stream sides idle and stall at random; the radix register is
// written and read back only while the converter is drained.
// ----------------------------------------------------------------------------
module tb;
  import ira_pkg::*;

  // one digit beat as seen on the master side
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
    logic       empty_flag;
  } digit_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;    // [30:0] value, [31] zero fill
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [6:0] digit_char, [7] zero fill
  logic        m_tlast;         // last
  logic        m_tuser;         // empty_res
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  integer_to_radix_ascii_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // bench copy of the radix register, raw as written
  logic [5:0]  radix_reg = RADIX_RESET;

  logic [30:0] pending_values[$];   // values waiting for the driver
  digit_beat_t expected_digits[$];  // digit beats still owed by the converter

  bit in_beat_taken = 1'b0;   // set at the edge where an input beat went in
  bit in_steady = 1'b0;       // stretch with no input gaps
  bit out_steady = 1'b0;      // stretch with no output stalls
  int in_gap = 0;
  int out_stall = 0;

  int mismatch_count = 0;
  int values_accepted = 0;
  int digits_checked = 0;
  int radix_writes = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("%0t: timeout, %0d digit beats still expected", $time, expected_digits.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // digit predictor
  // --------------------------------------------------------------------------

  // radix as the converter uses it: out-of-range settings saturate
  function automatic logic [5:0] active_radix();
    if (radix_reg < RADIX_MIN) return RADIX_MIN;
    if (radix_reg > RADIX_MAX) return RADIX_MAX;
    return radix_reg;
  endfunction

  // split a value into remainders, then queue them most significant first
  function automatic void predict_digits(input logic [30:0] value);
    logic [5:0]  base;
    logic [5:0]  rems[$];
    logic [30:0] q;
    logic [5:0]  d;
    digit_beat_t b;
    base = active_radix();
    if (value == '0) begin
      // zero has no digits: a lone flagged beat with a null character
      b = '{ch: 7'd0, last: 1'b1, empty_flag: 1'b1};
      expected_digits.push_back(b);
      return;
    end
    q = value;
    while (q != '0) begin
      rems.push_back(6'(q % base));
      q = q / base;
    end
    for (int k = rems.size() - 1; k >= 0; k--) begin
      d = rems[k];
      b.ch = (d < 6'd10) ? ASCII_ZERO + 7'(d) : ASCII_A + 7'(d) - 7'd10;
      b.last = (k == 0);
      b.empty_flag = 1'b0;
      expected_digits.push_back(b);
    end
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(input bit steady);
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // random value shaped around the current radix
  function automatic logic [30:0] random_value();
    int unsigned roll;
    logic [63:0] p;
    logic [5:0]  base;
    int          w;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 38) return 31'($urandom);
    if (roll < 58) return 31'($urandom_range(1000));
    if (roll < 80) begin
      // around a power of the radix: digit count rolls over here
      base = active_radix();
      p = 64'd1;
      repeat ($urandom_range(30)) begin
        if (p * base <= 64'h7FFF_FFFF) p = p * base;
      end
      return 31'(p + 64'($urandom_range(2)) - 64'd1);
    end
    w = $urandom_range(31, 1);
    return 31'($urandom & ((32'd1 << w) - 32'd1));
  endfunction

  // --------------------------------------------------------------------------
  // register port, driven on the falling edge
  // --------------------------------------------------------------------------

  task automatic apb_access(input bit is_write, input logic [31:0] wdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = is_write;
    paddr   = REG_RADIX_ADDR;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // write the radix, then read it back
  task automatic set_radix(input logic [5:0] r);
    apb_access(1'b1, {26'b0, r});
    radix_reg = r;
    radix_writes++;
    apb_access(1'b0, '0);
  endtask

  // let every queued value go in and every owed digit come out
  task automatic drain();
    // checked on the rising edge, where the driver's last update has settled
    while (pending_values.size() != 0 || s_tvalid || expected_digits.size() != 0)
      @(posedge clk);
    // every value yields a beat, so the block is idle once the queue is empty;
    // the trailing wait on the falling edge is margin only
    repeat (8) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // input driver: values from the pending queue, random gaps between beats
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_beat_taken) begin
      // beat still waiting for tready: hold it
    end else if (in_gap > 0) begin
      in_gap--;
      s_tvalid <= 1'b0;
    end else if (pending_values.size() != 0) begin
      s_tdata  <= {1'b0, pending_values.pop_front()};
      s_tvalid <= 1'b1;
      if ($urandom_range(29) == 0) in_steady = !in_steady;
      in_gap = pick_gap(in_steady);
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // output side: random tready stalls
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(199) == 0) out_steady = !out_steady;
      out_stall = pick_gap(out_steady);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predict on each accepted value, check each accepted digit beat
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    digit_beat_t want;
    digit_beat_t got;
    in_beat_taken = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        in_beat_taken = 1'b1;
        values_accepted++;
        predict_digits(s_tdata[30:0]);
      end
      if (m_tvalid && m_tready) begin
        got = '{ch: m_tdata[6:0], last: m_tlast, empty_flag: m_tuser};
        if (expected_digits.size() == 0) begin
          mismatch_count++;
          $display("%0t: digit beat with none expected: char %0d last %0b empty %0b",
                   $time, got.ch, got.last, got.empty_flag);
        end else begin
          want = expected_digits.pop_front();
          digits_checked++;
          if (got.ch !== want.ch || got.last !== want.last ||
              got.empty_flag !== want.empty_flag) begin
            mismatch_count++;
            $display("%0t: digit mismatch, expected char %0d last %0b empty %0b",
                     $time, want.ch, want.last, want.empty_flag,
                     ", got char %0d last %0b empty %0b",
                     got.ch, got.last, got.empty_flag);
          end
        end
      end
      // register read-back
      if (psel && penable && pready && !pwrite) begin
        if (prdata !== {26'b0, radix_reg}) begin
          mismatch_count++;
          $display("%0t: radix read mismatch, expected %0d, got %0d",
                   $time, radix_reg, prdata);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [5:0] phase_radix[$];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset value of the radix register
    apb_access(1'b0, '0);

    // directed, radix 36 from reset: zero, single digits, roll-overs, all-ones,
    // alternating bit patterns
    pending_values = '{31'd0, 31'd1, 31'd9, 31'd10, 31'd35, 31'd36, 31'd1295,
                       31'd1296, 31'h7FFF_FFFF, 31'h5555_5555, 31'h2AAA_AAAA};
    drain();

    // radix 0 saturates to two: all-ones gives the longest digit string
    set_radix(6'd0);
    pending_values = '{31'h7FFF_FFFF, 31'd1, 31'd0, 31'h4000_0000, 31'd2};
    drain();

    // radix 63 saturates to thirty-six
    set_radix(6'd63);
    pending_values = '{31'd35, 31'd36, 31'd46655};
    drain();

    // radix 1 saturates to two
    set_radix(6'd1);
    pending_values = '{31'd5, 31'h3FFF_FFFF};
    drain();

    // random phases, one radix each, extremes and out-of-range settings included
    phase_radix = '{6'd2, 6'd10, 6'd16, 6'd36, 6'd0, 6'd63, 6'd1, 6'd37, 6'd8,
                    6'($urandom_range(63)), 6'($urandom_range(63))};
    foreach (phase_radix[i]) begin
      set_radix(phase_radix[i]);
      repeat (40) pending_values.push_back(random_value());
      drain();
    end

    // trailing cycles to catch stray beats
    repeat (60) @(negedge clk);

    $display("converted %0d values into %0d checked digit beats", values_accepted,
             digits_checked);
    $display("radix written %0d times, saturated settings and both stream stalls included",
             radix_writes);
    if (mismatch_count == 0 && expected_digits.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d digit beats never arrived", mismatch_count,
               expected_digits.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* integer_to_radix_ascii_top.f */
hw/rtl/ira_pkg.sv
hw/rtl/ira_ram.sv
hw/rtl/ira_divider.sv
hw/rtl/integer_to_radix_ascii_top.sv
tb/sv/tb.sv
